// ----- design/assert_macros.svh -----
// Assertion macros shared by the sorted event key table RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a plain condition on every clock edge, reset included.
`define CHK_ALWAYS(label, clk, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

// ----- design/sekt_pkg.sv -----
// Package for the sorted event key table: entry type, status codes and ops.
// Depends on nothing; used by sekt_store, sorted_event_key_table and the testbench.
package sekt_pkg;

    typedef struct packed {
        logic [7:0]  tag;
        logic [5:0]  em;
        logic [4:0]  eh;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  sh;
        logic [5:0]  sm;
    } entry_t;

    localparam int EntryW = 53;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LIST_DATE = 2'd2;
    localparam logic [1:0] OP_LIST_ALL = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD_DATE = 3'd1;
    localparam logic [2:0] ST_BAD_TIME = 3'd2;
    localparam logic [2:0] ST_DUP = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;
    localparam logic [2:0] ST_EMPTY = 3'd6;
    localparam logic [2:0] ST_ENTRY = 3'd7;

    localparam logic [13:0] MIN_YEAR_RESET = 14'd2022;
    localparam logic [4:0]  MAX_DAY = 5'd31;
    localparam logic [3:0]  MAX_MONTH = 4'd12;
    localparam logic [4:0]  MAX_HOUR = 5'd23;
    localparam logic [5:0]  MAX_MINUTE = 6'd59;

    // Sort key: year, month, day, start hour, start minute.
    function automatic logic [33:0] key_of(input entry_t e);
        key_of = {e.year, e.month, e.day, e.sh, e.sm};
    endfunction

    typedef struct packed {
        logic       out_valid;
        logic [2:0] status;
        logic       last;
    } result_t;

endpackage

// ----- design/sekt_store.sv -----
// Entry memory for the sorted event key table: one write port, one read port,
// registered read data. Depends on sekt_pkg.
module sekt_store #(
    parameter int DEPTH = 16,
    parameter int AW = 4
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  sekt_pkg::entry_t     wdata,
    input  logic [AW-1:0]        raddr,
    output sekt_pkg::entry_t     rdata
);

    sekt_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/sorted_event_key_table.sv -----
// Sorted event key table: memory-backed sorted list with insert, remove and listing.
// Depends on sekt_pkg, sekt_store and assert_macros.svh.
//
// One command word is taken at a time. The table sits in a single-port-read,
// single-port-write memory with registered read data: insert and remove scan
// the valid entries one per cycle (up to CAPACITY reads), then move the tail
// by one slot at a time (a read, then the write back) before the status word.
// Listing reads one entry at a time, holds each match back by one so tlast is
// known, and waits on m_axis_tready before each read while a word is pending.
// Empty or rejected commands put out their status word the cycle after
// acceptance; the next command can be taken in the cycle after that word leaves.
// min_year may be written only while no command is busy.
`include "assert_macros.svh"
module sorted_event_key_table #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [13:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: day[4:0] month[8:5] year[22:9] start_hour[27:23] start_minute[33:28]
    //        end_hour[38:34] end_minute[44:39] tag[52:45], zero fill to 56
    input  logic [55:0] s_axis_tdata,
    // tuser: operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: out_day[4:0] out_month[8:5] out_year[22:9] out_start_hour[27:23]
    //        out_start_minute[33:28] out_end_hour[38:34] out_end_minute[44:39]
    //        out_tag[52:45], zero fill to 56
    output logic [55:0] m_axis_tdata,
    // tuser: status
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_SHUP = 3'd2;
    localparam logic [2:0] S_SHDN = 3'd3;
    localparam logic [2:0] S_LIST = 3'd4;
    localparam logic [2:0] S_RESP = 3'd5;
    localparam logic [2:0] S_LWAIT = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [13:0]      min_year_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;     // read address issued
    logic             rv_reg, rv_next;       // read data valid this cycle
    logic [CW-1:0]    ridx_reg, ridx_next;   // index of the data in rdata (its destination in S_SHUP)
    logic [CW-1:0]    pos_reg, pos_next;
    logic [1:0]       op_reg;
    sekt_pkg::entry_t cmd_reg;
    logic             found_reg, found_next;
    sekt_pkg::entry_t hold_reg, hold_next;   // pending listed entry
    logic             hold_v_reg, hold_v_next;

    sekt_pkg::result_t res_reg, res_next;
    sekt_pkg::entry_t  oent_reg, oent_next;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    sekt_pkg::entry_t wdata, rdata;
    sekt_pkg::entry_t in_ent;

    assign in_ent.day   = s_axis_tdata[4:0];
    assign in_ent.month = s_axis_tdata[8:5];
    assign in_ent.year  = s_axis_tdata[22:9];
    assign in_ent.sh    = s_axis_tdata[27:23];
    assign in_ent.sm    = s_axis_tdata[33:28];
    assign in_ent.eh    = s_axis_tdata[38:34];
    assign in_ent.em    = s_axis_tdata[44:39];
    assign in_ent.tag   = s_axis_tdata[52:45];

    sekt_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    wire accept = s_axis_tvalid && s_axis_tready;
    wire out_free = !res_reg.out_valid || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && !res_reg.out_valid;

    wire [33:0] rkey = sekt_pkg::key_of(rdata);
    wire [33:0] ckey = sekt_pkg::key_of(cmd_reg);
    wire date_eq = (rdata.day == cmd_reg.day) && (rdata.month == cmd_reg.month)
                   && (rdata.year == cmd_reg.year);

    function automatic logic time_ok(input logic [4:0] h, input logic [5:0] m);
        time_ok = (h <= sekt_pkg::MAX_HOUR) && (m <= sekt_pkg::MAX_MINUTE);
    endfunction

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        rv_next      = 1'b0;
        ridx_next    = idx_reg;
        pos_next     = pos_reg;
        found_next   = found_reg;
        hold_next    = hold_reg;
        hold_v_next  = hold_v_reg;
        res_next     = res_reg;
        oent_next    = oent_reg;
        we           = 1'b0;
        waddr        = idx_reg[AW-1:0];
        wdata        = rdata;
        raddr        = idx_reg[AW-1:0];

        if (res_reg.out_valid && m_axis_tready)
        begin
            res_next.out_valid = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next     = '0;
                    pos_next     = '0;
                    found_next   = 1'b0;
                    hold_v_next  = 1'b0;
                    oent_next    = '0;
                    res_next.last = 1'b1;
                    if (s_axis_tuser == sekt_pkg::OP_INSERT)
                    begin
                        if (in_ent.day == 5'd0 || in_ent.day > sekt_pkg::MAX_DAY
                            || in_ent.month == 4'd0 || in_ent.month > sekt_pkg::MAX_MONTH
                            || in_ent.year < min_year_reg)
                        begin
                            res_next.out_valid = 1'b1;
                            res_next.status = sekt_pkg::ST_BAD_DATE;
                        end
                        else if (!time_ok(in_ent.sh, in_ent.sm)
                                 || !time_ok(in_ent.eh, in_ent.em))
                        begin
                            res_next.out_valid = 1'b1;
                            res_next.status = sekt_pkg::ST_BAD_TIME;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_next.out_valid = 1'b1;
                        res_next.status = sekt_pkg::ST_EMPTY;
                    end
                    else if (s_axis_tuser == sekt_pkg::OP_REMOVE)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_LIST;
                    end
                end
            end

            S_SCAN:
            begin
                // issue reads 0..count-1; compare as data returns
                if (idx_reg < count_reg)
                begin
                    raddr   = idx_reg[AW-1:0];
                    rv_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                if (rv_reg && !found_reg)
                begin
                    if (rkey == ckey)
                    begin
                        found_next = 1'b1;
                        pos_next   = ridx_reg;
                    end
                    else if (rkey < ckey && op_reg == sekt_pkg::OP_INSERT)
                    begin
                        pos_next = ridx_reg + 1'b1;
                    end
                end
                if (idx_reg >= count_reg && !rv_reg)
                begin
                    rv_next = 1'b0;
                    res_next.out_valid = 1'b1;
                    res_next.last = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg == sekt_pkg::OP_INSERT)
                    begin
                        if (found_reg)
                        begin
                            res_next.status = sekt_pkg::ST_DUP;
                        end
                        else if (count_reg >= CAP_C)
                        begin
                            res_next.status = sekt_pkg::ST_FULL;
                        end
                        else
                        begin
                            // shift tail up from the top, then drop in the new entry
                            res_next.out_valid = 1'b0;
                            idx_next = count_reg;
                            state_next = S_SHUP;
                        end
                    end
                    else if (found_reg)
                    begin
                        res_next.out_valid = 1'b0;
                        idx_next = pos_reg + 1'b1;
                        state_next = S_SHDN;
                    end
                    else
                    begin
                        res_next.status = sekt_pkg::ST_NOT_FOUND;
                    end
                end
            end

            S_SHUP:
            begin
                // idx is destination; read idx-1, write next cycle
                if (rv_reg)
                begin
                    we    = 1'b1;
                    waddr = ridx_reg[AW-1:0];
                    wdata = rdata;
                end
                else if (idx_reg > pos_reg)
                begin
                    raddr     = AW'(idx_reg - 1'b1);
                    rv_next   = 1'b1;
                    ridx_next = idx_reg;
                    idx_next  = idx_reg - 1'b1;
                end
                else
                begin
                    we    = 1'b1;
                    waddr = pos_reg[AW-1:0];
                    wdata = cmd_reg;
                    count_next = count_reg + 1'b1;
                    res_next.out_valid = 1'b1;
                    res_next.status = sekt_pkg::ST_OK;
                    state_next = S_IDLE;
                end
            end

            S_SHDN:
            begin
                // idx is source; read idx, write to idx-1
                if (rv_reg)
                begin
                    we    = 1'b1;
                    waddr = AW'(ridx_reg - 1'b1);
                    wdata = rdata;
                end
                else if (idx_reg < count_reg)
                begin
                    raddr    = idx_reg[AW-1:0];
                    rv_next  = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    res_next.out_valid = 1'b1;
                    res_next.status = sekt_pkg::ST_OK;
                    state_next = S_IDLE;
                end
            end

            S_LIST:
            begin
                // keep one matching entry in hold so tlast is known at emit
                if (rv_reg)
                begin
                    if (op_reg == sekt_pkg::OP_LIST_ALL || date_eq)
                    begin
                        if (hold_v_reg)
                        begin
                            res_next.out_valid = 1'b1;
                            res_next.status = sekt_pkg::ST_ENTRY;
                            res_next.last = 1'b0;
                            oent_next = hold_reg;
                        end
                        hold_next   = rdata;
                        hold_v_next = 1'b1;
                    end
                    state_next = S_LWAIT;
                end
                else if (idx_reg < count_reg)
                begin
                    if (out_free)
                    begin
                        raddr    = idx_reg[AW-1:0];
                        rv_next  = 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (out_free)
                begin
                    res_next.out_valid = 1'b1;
                    res_next.last = 1'b1;
                    if (hold_v_reg)
                    begin
                        res_next.status = sekt_pkg::ST_ENTRY;
                        oent_next = hold_reg;
                    end
                    else
                    begin
                        res_next.status = sekt_pkg::ST_NOT_FOUND;
                        oent_next = '0;
                    end
                    state_next = S_RESP;
                end
            end

            S_LWAIT:
            begin
                state_next = S_LIST;
            end

            S_RESP:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            min_year_reg <= sekt_pkg::MIN_YEAR_RESET;
            rv_reg       <= 1'b0;
            res_reg      <= '0;
            hold_v_reg   <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rv_reg      <= rv_next;
            res_reg     <= res_next;
            hold_v_reg  <= hold_v_next;
            found_reg   <= found_next;
            if (cfg_we)
            begin
                min_year_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        ridx_reg <= ridx_next;
        pos_reg  <= pos_next;
        hold_reg <= hold_next;
        oent_reg <= oent_next;
        if (accept)
        begin
            op_reg  <= s_axis_tuser;
            cmd_reg <= in_ent;
        end
    end

    assign m_axis_tvalid = res_reg.out_valid;
    assign m_axis_tuser  = res_reg.status;
    assign m_axis_tlast  = res_reg.last;
    assign m_axis_tdata  = {3'b000, oent_reg.tag, oent_reg.em, oent_reg.eh, oent_reg.sm,
                            oent_reg.sh, oent_reg.year, oent_reg.month, oent_reg.day};

    `CHK_IMPL(a_count_cap, clk, rst_n, count_reg <= CAP_C, "entry count above capacity")
    `CHK_IMPL(a_entry_not_last_only_list, clk, rst_n,
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == sekt_pkg::ST_ENTRY),
        "non-final word without entry status")
    `CHK_IMPL(a_ready_idle, clk, rst_n,
        s_axis_tready |-> (state_reg == S_IDLE), "command taken while busy")
    `CHK_IMPL(a_count_step, clk, rst_n,
        (count_reg != $past(count_reg)) |->
        (count_reg == $past(count_reg) + 1'b1 || count_reg == $past(count_reg) - 1'b1),
        "entry count jumped")

endmodule

// ----- bench/sorted_event_key_table_tb.sv -----
// Testbench for sorted_event_key_table: drives insert, remove and list words on the
// input stream and checks every output word against an in-bench table predictor.
// Depends on sekt_pkg and the sorted_event_key_table RTL.
module sorted_event_key_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  tag;
        logic [5:0]  em;
        logic [4:0]  eh;
        logic [5:0]  sm;
        logic [4:0]  sh;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } cmd_fields_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [52:0] body;
        logic        last;
    } result_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [13:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    sorted_event_key_table i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor state
    cmd_fields_t  table_rows[16];
    int           row_count = 0;
    logic [13:0]  year_floor = sekt_pkg::MIN_YEAR_RESET;
    result_word_t pending_words[$];

    int  errors = 0;
    int  words_seen = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 1'b0;
    int  hold_cycles = 0;
    int  cycle_count = 0;
    int  sent_items = 0;

    function automatic logic [33:0] sort_key(cmd_fields_t f);
        return {f.year, f.month, f.day, f.sh, f.sm};
    endfunction

    function automatic result_word_t status_word(logic [2:0] st);
        result_word_t w;
        w.status = st;
        w.body = '0;
        w.last = 1'b1;
        return w;
    endfunction

    function automatic result_word_t row_word(cmd_fields_t f, bit fin);
        result_word_t w;
        w.status = sekt_pkg::ST_ENTRY;
        w.body = f;
        w.last = fin;
        return w;
    endfunction

    task automatic predict_table(logic [1:0] op, cmd_fields_t f);
        int pos;
        int hits;
        bit found;
        pos = 0;
        hits = 0;
        found = 1'b0;
        if (op == sekt_pkg::OP_INSERT)
        begin
            if (f.day < 1 || f.month < 1 || f.month > sekt_pkg::MAX_MONTH
                || f.year < year_floor)
            begin
                pending_words.push_back(status_word(sekt_pkg::ST_BAD_DATE));
                return;
            end
            if (f.sh > sekt_pkg::MAX_HOUR || f.sm > sekt_pkg::MAX_MINUTE
                || f.eh > sekt_pkg::MAX_HOUR || f.em > sekt_pkg::MAX_MINUTE)
            begin
                pending_words.push_back(status_word(sekt_pkg::ST_BAD_TIME));
                return;
            end
            for (int i = 0; i < row_count; i++)
            begin
                if (sort_key(table_rows[i]) == sort_key(f)) found = 1'b1;
                if (sort_key(table_rows[i]) < sort_key(f)) pos = i + 1;
            end
            if (found) pending_words.push_back(status_word(sekt_pkg::ST_DUP));
            else if (row_count >= 16) pending_words.push_back(status_word(sekt_pkg::ST_FULL));
            else
            begin
                for (int i = row_count; i > pos; i--) table_rows[i] = table_rows[i-1];
                table_rows[pos] = f;
                row_count++;
                pending_words.push_back(status_word(sekt_pkg::ST_OK));
            end
            return;
        end
        if (row_count == 0)
        begin
            pending_words.push_back(status_word(sekt_pkg::ST_EMPTY));
            return;
        end
        if (op == sekt_pkg::OP_REMOVE)
        begin
            for (int i = 0; i < row_count && !found; i++)
                if (sort_key(table_rows[i]) == sort_key(f))
                begin
                    found = 1'b1;
                    for (int j = i; j + 1 < row_count; j++) table_rows[j] = table_rows[j+1];
                    row_count--;
                end
            pending_words.push_back(status_word(found ? sekt_pkg::ST_OK
                                                      : sekt_pkg::ST_NOT_FOUND));
            return;
        end
        for (int i = 0; i < row_count; i++)
            if (op == sekt_pkg::OP_LIST_ALL || (table_rows[i].day == f.day &&
                table_rows[i].month == f.month && table_rows[i].year == f.year))
            begin
                pending_words.push_back(row_word(table_rows[i], 1'b0));
                hits++;
            end
        if (hits == 0) pending_words.push_back(status_word(sekt_pkg::ST_NOT_FOUND));
        else pending_words[pending_words.size()-1].last = 1'b1;
    endtask

    // Drop valid after the accept; the block is busy then anyway.
    task automatic send_word(logic [1:0] op, cmd_fields_t f);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {3'b000, f};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_table(op, f);
        sent_items++;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (pending_words.size() > 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_floor(logic [13:0] v);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        year_floor = v;
    endtask

    function automatic cmd_fields_t make_fields(int d, int m, int y, int sh, int sm,
                                                int eh, int em, int tg);
        cmd_fields_t f;
        f.day = 5'(d); f.month = 4'(m); f.year = 14'(y); f.sh = 5'(sh); f.sm = 6'(sm);
        f.eh = 5'(eh); f.em = 6'(em); f.tag = 8'(tg);
        return f;
    endfunction

    // Mostly valid keys over a narrow space so duplicates, hits and removals happen.
    function automatic cmd_fields_t valid_fields();
        return make_fields($urandom_range(1, 3), $urandom_range(1, 2),
                           year_floor + $urandom_range(0, 1), $urandom_range(0, 2) * 11,
                           $urandom_range(0, 1) * 59, $urandom_range(0, 23),
                           $urandom_range(0, 59), $urandom_range(0, 255));
    endfunction

    function automatic cmd_fields_t noise_fields();
        cmd_fields_t f;
        f = cmd_fields_t'(53'({$urandom, $urandom}));
        return f;
    endfunction

    task automatic test_directed();
        send_word(sekt_pkg::OP_LIST_ALL, make_fields(0, 0, 0, 0, 0, 0, 0, 0));
        send_word(sekt_pkg::OP_REMOVE, make_fields(1, 1, 2022, 0, 0, 0, 0, 0));
        send_word(sekt_pkg::OP_LIST_DATE, make_fields(1, 1, 2022, 0, 0, 0, 0, 0));
        send_word(sekt_pkg::OP_INSERT, make_fields(0, 1, 2022, 0, 0, 0, 0, 1));
        send_word(sekt_pkg::OP_INSERT, make_fields(31, 13, 2022, 0, 0, 0, 0, 1));
        send_word(sekt_pkg::OP_INSERT, make_fields(5, 0, 2022, 0, 0, 0, 0, 1));
        send_word(sekt_pkg::OP_INSERT, make_fields(5, 5, 2021, 0, 0, 0, 0, 1));
        send_word(sekt_pkg::OP_INSERT, make_fields(5, 5, 2022, 24, 0, 0, 0, 1));
        send_word(sekt_pkg::OP_INSERT, make_fields(5, 5, 2022, 0, 60, 0, 0, 1));
        send_word(sekt_pkg::OP_INSERT, make_fields(5, 5, 2022, 0, 0, 31, 0, 1));
        send_word(sekt_pkg::OP_INSERT, make_fields(5, 5, 2022, 0, 0, 0, 63, 1));
        send_word(sekt_pkg::OP_INSERT, make_fields(31, 12, 16383, 23, 59, 23, 59, 255));
        send_word(sekt_pkg::OP_INSERT, make_fields(1, 1, 2022, 0, 0, 0, 0, 0));
        send_word(sekt_pkg::OP_INSERT, make_fields(1, 1, 2022, 0, 0, 5, 5, 7));
        send_word(sekt_pkg::OP_INSERT, make_fields(1, 1, 2022, 23, 59, 1, 1, 170));
        send_word(sekt_pkg::OP_LIST_DATE, make_fields(1, 1, 2022, 31, 63, 31, 63, 255));
        send_word(sekt_pkg::OP_LIST_DATE, make_fields(2, 1, 2022, 0, 0, 0, 0, 0));
        send_word(sekt_pkg::OP_LIST_ALL, make_fields(31, 15, 16383, 31, 63, 31, 63, 255));
        send_word(sekt_pkg::OP_REMOVE, make_fields(31, 15, 16383, 31, 63, 0, 0, 0));
        send_word(sekt_pkg::OP_REMOVE, make_fields(1, 1, 2022, 23, 59, 0, 0, 0));
        send_word(sekt_pkg::OP_LIST_ALL, make_fields(0, 0, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 17; i++)
            send_word(sekt_pkg::OP_INSERT, make_fields(10, 6, 3000, i, 30, 1, 2, i));
        send_word(sekt_pkg::OP_LIST_ALL, make_fields(0, 0, 0, 0, 0, 0, 0, 0));
        write_floor(14'd0);
        send_word(sekt_pkg::OP_INSERT, make_fields(1, 1, 0, 0, 0, 0, 0, 0));
        write_floor(14'd16383);
        send_word(sekt_pkg::OP_INSERT, make_fields(1, 1, 16382, 0, 0, 0, 0, 0));
        for (int i = 0; i < 17; i++)
            send_word(sekt_pkg::OP_REMOVE, make_fields(10, 6, 3000, i, 30, 0, 0, 0));
        send_word(sekt_pkg::OP_REMOVE, make_fields(1, 1, 2022, 0, 0, 0, 0, 0));
        send_word(sekt_pkg::OP_REMOVE, make_fields(31, 12, 16383, 23, 59, 0, 0, 0));
    endtask

    task automatic test_random(int n, logic [13:0] floor_v);
        int r;
        write_floor(floor_v);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 45) send_word(sekt_pkg::OP_INSERT, valid_fields());
            else if (r < 65) send_word(sekt_pkg::OP_REMOVE, valid_fields());
            else if (r < 78) send_word(sekt_pkg::OP_LIST_DATE, valid_fields());
            else if (r < 88) send_word(sekt_pkg::OP_LIST_ALL, valid_fields());
            else send_word(2'($urandom_range(3)), noise_fields());
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 6; i++) send_word(sekt_pkg::OP_LIST_ALL, valid_fields());
        send_word(sekt_pkg::OP_INSERT, valid_fields());
        drain_results();
        send_word(sekt_pkg::OP_LIST_ALL, valid_fields());
    endtask

    // Receiver: random stalls, plus one long hold-off counted here.
    always @(posedge clk)
    begin
        if (hold_off)
        begin
            m_axis_tready <= 1'b0;
            if (hold_cycles == 299)
            begin
                hold_off <= 1'b0;
                hold_cycles <= 0;
            end
            else
            begin
                hold_cycles <= hold_cycles + 1;
            end
        end
        else
        begin
            m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        result_word_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1000000)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_seen++;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word status=%0d data=%h", $realtime,
                         m_axis_tuser, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (m_axis_tuser !== want.status || m_axis_tdata !== {3'b000, want.body} ||
                    m_axis_tlast !== want.last)
                begin
                    $display("%0t: mismatch expected st=%0d data=%h last=%b",
                             $realtime, want.status, want.body, want.last);
                    $display("    got st=%0d data=%h last=%b",
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(65, 14'd2022);
        send_idle_pct = 49;
        test_random(65, 14'd2023);
        send_idle_pct = 0;
        recv_stall_pct = 49;
        test_random(65, 14'd2022);
        send_idle_pct = 9;
        recv_stall_pct = 9;
        test_random(65, 14'd2030);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        drain_results();
        if (pending_words.size() != 0) errors++;
        $display("Sent %0d command words, checked %0d result words over four idle mixes",
                 sent_items, words_seen);
        $display("including empty/full table, bad fields, duplicates and a long output stall");
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
